// ----- rtl/deque_with_delete_by_value_defines.svh -----
// Assertion macros shared by the checker of the deque block.
// Needs nothing else; include it by its bare file name.
`ifndef DEQUE_WITH_DELETE_BY_VALUE_DEFINES_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define DWD_ASSERT_NOW(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("dwd check failed");

// Checks that a condition in one cycle is followed by another in the next.
`define DWD_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dwd check failed");

`endif

// ----- rtl/dwd_pkg.sv -----
// Shared types and codes of the deque with delete by value.
// Has no dependencies; the cells, the chain and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package dwd_pkg;

  localparam int VAL_W    = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEL_VALUE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_ITEM  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  head;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/dwd_cell.sv -----
// One storage cell of the list row, holding one value.
// Depends on dwd_pkg for the cell operation codes.
`timescale 1ns / 1ps
`default_nettype none

module dwd_cell (
  input  wire                              clk,
  input  dwd_pkg::cell_ctrl_t              ctrl,
  input  wire                              is_last,
  input  wire signed [dwd_pkg::VAL_W-1:0]  from_left,
  input  wire signed [dwd_pkg::VAL_W-1:0]  from_right,
  output logic signed [dwd_pkg::VAL_W-1:0] value
);
  import dwd_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_LOAD: begin
        value <= from_left;
      end
      CELL_LEFT: begin
        value <= from_right;
      end
      CELL_ROTATE: begin
        value <= is_last ? ctrl.head : from_right;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/dwd_chain.sv -----
// Row of list cells, front at cell zero, linked to their neighbors.
// Depends on dwd_pkg and dwd_cell.
`timescale 1ns / 1ps
`default_nettype none

module dwd_chain #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7
) (
  input  wire                              clk,
  input  dwd_pkg::cell_op_t                op,
  input  wire signed [dwd_pkg::VAL_W-1:0]  in_value,
  input  wire [CNT_W-1:0]                  count,
  output logic signed [dwd_pkg::VAL_W-1:0] head
);
  import dwd_pkg::*;

  logic signed [VAL_W-1:0] vals [CAPACITY];
  cell_ctrl_t              ctrl;

  assign head      = vals[0];
  assign ctrl.op   = op;
  assign ctrl.head = vals[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;
    logic                    last_here;

    if (i == 0) begin : g_first
      assign left_val = in_value;
    end else begin : g_mid_left
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = vals[0];
    end else begin : g_mid_right
      assign right_val = vals[i+1];
    end

    assign last_here = (count == CNT_W'(i + 1));

    dwd_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .is_last    (last_here),
      .from_left  (left_val),
      .from_right (right_val),
      .value      (vals[i])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/deque_with_delete_by_value.sv -----
// Ordered list of up to CAPACITY signed 32-bit values kept in a row of cells,
// front first. Insert at the front, delete first and delete last each give
// one result. Delete by value rotates the list through the cell row once,
// one value per cycle, before its single result. Dump also rotates the row
// and emits one value per cycle, slower when the output stalls.
// One request is worked on at a time; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_delete_by_value #(
  parameter int CAPACITY = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire [dwd_pkg::VAL_W-1:0]            s_tdata,  // value
  input  wire [dwd_pkg::KIND_W-1:0]           s_tuser,  // kind
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [dwd_pkg::VAL_W-1:0]           m_tdata,  // item_value
  output logic [dwd_pkg::STATUS_W-1:0]        m_tuser,  // status
  output logic                                m_tlast   // last_item
);
  import dwd_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DUMP
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        steps;
  logic signed [VAL_W-1:0] key;
  logic                    found;

  logic                    out_free;
  logic                    in_fire;
  logic                    head_match;
  logic signed [VAL_W-1:0] head;
  cell_op_t                op;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign in_fire    = s_tvalid && s_tready;
  assign head_match = (head == key);

  always_comb begin
    op = CELL_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_tuser == KIND_INSERT && count != CNT_W'(CAPACITY)) begin
            op = CELL_LOAD;
          end else if (s_tuser == KIND_DEL_FIRST && count != '0) begin
            op = CELL_LEFT;
          end
        end
      end
      ST_SEARCH: begin
        if (steps != '0) begin
          op = (!found && head_match) ? CELL_LEFT : CELL_ROTATE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          op = CELL_ROTATE;
        end
      end
      default: begin
        op = CELL_HOLD;
      end
    endcase
  end

  dwd_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk      (clk),
    .op       (op),
    .in_value (s_tdata),
    .count    (count),
    .head     (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      steps    <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            m_tlast <= 1'b1;
            m_tdata <= '0;
            case (s_tuser)
              KIND_INSERT: begin
                m_tvalid <= 1'b1;
                if (count == CNT_W'(CAPACITY)) begin
                  m_tuser <= STATUS_FULL;
                end else begin
                  m_tuser <= STATUS_DONE;
                  count   <= count + 1'b1;
                end
              end
              KIND_DEL_VALUE: begin
                m_tvalid <= 1'b0;
                key      <= s_tdata;
                found    <= 1'b0;
                steps    <= count;
                state    <= ST_SEARCH;
              end
              KIND_DEL_FIRST, KIND_DEL_LAST: begin
                m_tvalid <= 1'b1;
                if (count == '0) begin
                  m_tuser <= STATUS_EMPTY;
                end else begin
                  m_tuser <= STATUS_DONE;
                  count   <= count - 1'b1;
                end
              end
              KIND_DUMP: begin
                if (count == '0) begin
                  m_tvalid <= 1'b1;
                  m_tuser  <= STATUS_EMPTY;
                end else begin
                  m_tvalid <= 1'b0;
                  steps    <= count;
                  state    <= ST_DUMP;
                end
              end
              default: begin
                m_tvalid <= 1'b1;
                m_tuser  <= STATUS_DONE;
              end
            endcase
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_SEARCH: begin
          if (steps != '0) begin
            steps <= steps - 1'b1;
            if (!found && head_match) begin
              found <= 1'b1;
              count <= count - 1'b1;
            end
            if (m_tready) begin
              m_tvalid <= 1'b0;
            end
          end else if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= 1'b1;
            m_tdata  <= '0;
            m_tuser  <= found ? STATUS_DONE : STATUS_EMPTY;
            state    <= ST_IDLE;
          end
        end
        ST_DUMP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tlast  <= (steps == CNT_W'(1));
            m_tdata  <= head;
            m_tuser  <= STATUS_ITEM;
            steps    <= steps - 1'b1;
            if (steps == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dwd_checker.sv -----
// Port-level checks of the deque block and the bind that attaches them.
// Depends on dwd_pkg and deque_with_delete_by_value_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_delete_by_value_defines.svh"

module dwd_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tvalid,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [dwd_pkg::VAL_W-1:0]        m_tdata,
  input wire [dwd_pkg::STATUS_W-1:0]     m_tuser,
  input wire                             m_tlast
);
  import dwd_pkg::*;

  // A stalled result holds.
  `DWD_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Only dump items carry a value.
  `DWD_ASSERT_NOW(a_zero_data, clk, rst,
    !(m_tvalid && m_tuser != STATUS_ITEM) || m_tdata == '0)

  // Every result other than a dump item ends its request.
  `DWD_ASSERT_NOW(a_single_last, clk, rst,
    !(m_tvalid && m_tuser != STATUS_ITEM) || m_tlast)

  // No new request is taken while a dump is still running.
  `DWD_ASSERT_NOW(a_dump_blocks, clk, rst,
    !(m_tvalid && m_tuser == STATUS_ITEM && !m_tlast) || !(s_tvalid && s_tready))

endmodule

bind deque_with_delete_by_value dwd_checker u_dwd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for deque_with_delete_by_value over its request and result streams.
// Needs dwd_pkg and the deque RTL; a value queue predicts each result not set by the script.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import dwd_pkg::*;

  localparam int LIST_CAP = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 50;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    item_value;
    logic                last_item;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [VAL_W-1:0]    value;
    bit                  typed;
    logic [STATUS_W-1:0] status;
  } script_row_t;

  localparam int SCRIPT_LEN = 23;
  localparam script_row_t DIRECTED_SCRIPT [SCRIPT_LEN] = '{
    '{KIND_DUMP,       32'h0000_0000, 1'b1, STATUS_EMPTY},
    '{KIND_DEL_VALUE,  32'h0000_0000, 1'b1, STATUS_EMPTY},
    '{KIND_DEL_FIRST,  32'h0000_0000, 1'b1, STATUS_EMPTY},
    '{KIND_DEL_LAST,   32'h0000_0000, 1'b1, STATUS_EMPTY},
    '{KIND_UNUSED_LO,  32'hFFFF_FFFF, 1'b1, STATUS_DONE},
    '{KIND_UNUSED_MID, 32'h0000_0000, 1'b1, STATUS_DONE},
    '{KIND_UNUSED_HI,  32'h8000_0000, 1'b1, STATUS_DONE},
    '{KIND_INSERT,     32'h7FFF_FFFF, 1'b1, STATUS_DONE},
    '{KIND_INSERT,     32'h8000_0000, 1'b1, STATUS_DONE},
    '{KIND_INSERT,     32'h0000_0000, 1'b1, STATUS_DONE},
    '{KIND_INSERT,     32'hFFFF_FFFF, 1'b1, STATUS_DONE},
    '{KIND_INSERT,     32'h8000_0000, 1'b1, STATUS_DONE},
    '{KIND_DUMP,       32'h0000_0000, 1'b0, STATUS_DONE},
    '{KIND_DEL_VALUE,  32'h1234_5678, 1'b1, STATUS_EMPTY},
    '{KIND_DEL_VALUE,  32'h8000_0000, 1'b1, STATUS_DONE},
    '{KIND_DUMP,       32'h0000_0000, 1'b0, STATUS_DONE},
    '{KIND_DEL_VALUE,  32'h7FFF_FFFF, 1'b1, STATUS_DONE},
    '{KIND_DEL_FIRST,  32'hFFFF_FFFF, 1'b1, STATUS_DONE},
    '{KIND_DEL_LAST,   32'h0000_0000, 1'b1, STATUS_DONE},
    '{KIND_DUMP,       32'h0000_0000, 1'b0, STATUS_DONE},
    '{KIND_DEL_VALUE,  32'h0000_0000, 1'b1, STATUS_DONE},
    '{KIND_DUMP,       32'h0000_0000, 1'b1, STATUS_EMPTY},
    '{KIND_DEL_VALUE,  32'h0000_0000, 1'b1, STATUS_EMPTY}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [VAL_W-1:0]    s_tdata = '0;
  logic [KIND_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [VAL_W-1:0]    m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;

  logic [VAL_W-1:0] list_model[$];
  result_t          pending_results[$];

  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int dumps_issued = 0;
  int full_drops = 0;
  int empty_or_missed = 0;

  deque_with_delete_by_value #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),    // value
    .s_tuser(s_tuser),    // kind
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),    // item_value
    .m_tuser(m_tuser),    // status
    .m_tlast(m_tlast)     // last_item
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic result_t single_result(input logic [STATUS_W-1:0] status);
    single_result = '{status: status, item_value: '0, last_item: 1'b1};
  endfunction

  function automatic void predict_list_op(input logic [KIND_W-1:0] kind,
                                          input logic [VAL_W-1:0] value,
                                          output result_t outcome[$]);
    int hit;
    outcome = {};
    hit = -1;
    case (kind)
      KIND_INSERT: begin
        if (list_model.size() >= LIST_CAP) begin
          outcome.push_back(single_result(STATUS_FULL));
          full_drops++;
        end else begin
          list_model.push_front(value);
          outcome.push_back(single_result(STATUS_DONE));
        end
      end
      KIND_DEL_VALUE: begin
        foreach (list_model[i]) begin
          if (hit < 0 && list_model[i] == value) hit = i;
        end
        if (hit < 0) begin
          outcome.push_back(single_result(STATUS_EMPTY));
          empty_or_missed++;
        end else begin
          list_model.delete(hit);
          outcome.push_back(single_result(STATUS_DONE));
        end
      end
      KIND_DEL_FIRST, KIND_DEL_LAST: begin
        if (list_model.size() == 0) begin
          outcome.push_back(single_result(STATUS_EMPTY));
          empty_or_missed++;
        end else begin
          if (kind == KIND_DEL_FIRST) void'(list_model.pop_front());
          else void'(list_model.pop_back());
          outcome.push_back(single_result(STATUS_DONE));
        end
      end
      KIND_DUMP: begin
        dumps_issued++;
        if (list_model.size() == 0) begin
          outcome.push_back(single_result(STATUS_EMPTY));
          empty_or_missed++;
        end else begin
          foreach (list_model[i]) begin
            outcome.push_back('{status: STATUS_ITEM, item_value: list_model[i],
                                last_item: (i == list_model.size() - 1)});
          end
        end
      end
      default: outcome.push_back(single_result(STATUS_DONE));
    endcase
  endfunction

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value,
                          input bit typed, input logic [STATUS_W-1:0] typed_status);
    result_t outcome[$];
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    predict_list_op(kind, value, outcome);
    if (typed) begin
      outcome = {};
      outcome.push_back(single_result(typed_status));
    end
    foreach (outcome[i]) pending_results.push_back(outcome[i]);
    requests_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) pick_value = VAL_W'($signed($urandom_range(0, 15)) - 8);
    else if (roll < 85) pick_value = $urandom;
    else begin
      case ($urandom_range(0, 3))
        0: pick_value = 32'h8000_0000;
        1: pick_value = 32'h7FFF_FFFF;
        2: pick_value = 32'hFFFF_FFFF;
        default: pick_value = 32'h0000_0000;
      endcase
    end
  endfunction

  task automatic send_mixed(input int insert_pct);
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0] value;
    int roll;
    value = pick_value();
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < insert_pct) kind = KIND_INSERT;
    else if (roll < 45) begin
      kind = KIND_DEL_VALUE;
      if (list_model.size() != 0 && $urandom_range(0, 9) < 7)
        value = list_model[$urandom_range(0, list_model.size() - 1)];
    end
    else if (roll < 63) kind = KIND_DEL_FIRST;
    else if (roll < 81) kind = KIND_DEL_LAST;
    else if (roll < 95) kind = KIND_DUMP;
    else kind = KIND_W'(KIND_UNUSED_LO + $urandom_range(0, 2));
    send_req(kind, value, 1'b0, STATUS_DONE);
  endtask

  initial begin : result_checker
    int stall_left;
    int hold_left;
    result_t want;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status %0d value %h last %b",
                                  m_tuser, m_tdata, m_tlast));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (m_tuser !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
          if (m_tdata !== want.item_value)
            flag_mismatch($sformatf("item_value %h, expected %h", m_tdata, want.item_value));
          if (m_tlast !== want.last_item)
            flag_mismatch($sformatf("last_item %b, expected %b", m_tlast, want.last_item));
        end
      end
      if (hold_request) begin
        hold_request <= 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_SCRIPT[i])
      send_req(DIRECTED_SCRIPT[i].kind, DIRECTED_SCRIPT[i].value,
               DIRECTED_SCRIPT[i].typed, DIRECTED_SCRIPT[i].status);
    drain_results();

    repeat (110) send_mixed(50);
    drain_results();

    while (list_model.size() < LIST_CAP) send_req(KIND_INSERT, pick_value(), 1'b0, STATUS_DONE);
    repeat (4) send_req(KIND_INSERT, pick_value(), 1'b0, STATUS_DONE);
    send_req(KIND_DUMP, $urandom, 1'b0, STATUS_DONE);
    drain_results();

    // The output side holds off while requests keep coming, so the block backs up.
    hold_request <= 1'b1;
    repeat (16) send_mixed(30);
    drain_results();

    repeat (70) send_mixed(20);

    quiet = 1'b1;
    repeat (40) send_mixed(45);

    drain_results();
    repeat (2 * LIST_CAP) @(posedge clk);

    $display("Covered %0d requests, %0d of them dumps, with %0d dropped on a full list",
             requests_sent, dumps_issued, full_drops);
    $display("and %0d on an empty list or with no match; %0d results checked.",
             empty_or_missed, results_checked);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
